// File: rtl/vrpt_pkg.sv
// Shared types and constants of the video register port translator.
`default_nettype none
package vrpt_pkg;

	typedef struct packed {
		logic       op;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] target_address;
		logic [15:0] data;
		logic        last;
	} rsp_t;

	localparam logic OP_READ = 1'b0;

	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_PALETTE = 3'd1;
	localparam logic [2:0] KIND_TILEMAP = 3'd2;
	localparam logic [2:0] KIND_SCROLL  = 3'd3;
	localparam logic [2:0] KIND_ENABLE  = 3'd4;

	localparam logic [7:0] REG_SCREEN_FIRST = 8'h07;
	localparam logic [7:0] REG_SCREEN_LAST  = 8'h0A;
	localparam logic [7:0] REG_SCROLL_FIRST = 8'h0D;
	localparam logic [7:0] REG_SCROLL_LAST  = 8'h14;
	localparam logic [7:0] REG_VADDR_LO     = 8'h16;
	localparam logic [7:0] REG_VADDR_HI     = 8'h17;
	localparam logic [7:0] REG_VDATA_LO     = 8'h18;
	localparam logic [7:0] REG_VDATA_HI     = 8'h19;
	localparam logic [7:0] REG_PAL_INDEX    = 8'h21;
	localparam logic [7:0] REG_PAL_DATA     = 8'h22;
	localparam logic [7:0] REG_LAYER_EN     = 8'h2C;

	localparam logic [31:0] ADDR_TILEMAP = 32'h0604_0000;
	localparam logic [31:0] ADDR_PAL_BG  = 32'h0500_0000;
	localparam logic [31:0] ADDR_PAL_OBJ = 32'h0500_0200;
	localparam logic [31:0] ADDR_HSCROLL = 32'h0400_0010;
	localparam logic [31:0] ADDR_VSCROLL = 32'h0400_0012;
	localparam logic [31:0] ADDR_ENABLE  = 32'h0400_0000;

	localparam logic [7:0]  Y_OFFSET_RESET = 8'd16;
	localparam logic [15:0] COLOR_RESET    = 16'hFFFF;

	// Reduce a small value modulo m by four compare-and-subtract steps;
	// valid while v < 16*m.
	function automatic logic [8:0] mod_small(input logic [8:0] v, input logic [9:0] m);
		logic [12:0] r;
		logic [12:0] s;
		r = {4'b0, v};
		for (int k = 3; k >= 0; k--) begin
			s = {3'b0, m} << k;
			if (r >= s) r = r - s;
		end
		return r[8:0];
	endfunction

	function automatic logic [15:0] encode_tile(input logic [15:0] t);
		return {1'b0, t[12:10], t[15], t[14], t[9:0]};
	endfunction

endpackage
`default_nettype wire

// File: rtl/vrpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vrpt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: rtl/video_register_port_translator.sv
// Top level: register access translator with palette and block-usage memories.
//
// Usage: byte reads and writes of the emulated video register window enter on
// the req channel (valid/ready). Each beat yields zero to four translated
// beats on the rsp channel (valid/ready); the final one carries last. The
// vertical scroll offset is set via cfg_we/cfg_wdata, by the user only while idle; unenforced by the block.
//
// One access at a time: req_ready is high only in the idle state.
// Plain register writes stay in the idle state; reads, enable writes and a
// completing scroll write load one beat into the rsp register; palette writes
// emit two beats; a VRAM high-byte write emits one tile beat per layer using
// the block. A screen base change walks the block-usage memory read-modify-write,
// block by block through S_SRD and S_SWR, over the old and new spans.
// A stalled receiver holds the rsp register; the sequencer waits on it.
// Reset clears the sequencer and register-window state; palette and usage entries never written read as
// their reset values through per-entry valid flags, so no clearing pass.
`default_nettype none
module video_register_port_translator
	import vrpt_pkg::*;
#(
	parameter int LAYERS          = 4,
	parameter int USAGE_BLOCKS    = 64,
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp,
	input  wire logic cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	localparam int PAW = $clog2(PALETTE_ENTRIES);
	localparam int UAW = $clog2(USAGE_BLOCKS);
	localparam logic [9:0] PAL_M = 10'(PALETTE_ENTRIES);
	localparam logic [9:0] USE_M = 10'(USAGE_BLOCKS);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PRD  = 7'b0000010,
		S_URD  = 7'b0000100,
		S_TILE = 7'b0001000,
		S_EMIT = 7'b0010000,
		S_SRD  = 7'b0100000,
		S_SWR  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [7:0]  yoff_q;
	logic [7:0]  pal_idx_q;
	logic        pal_hi_q;
	logic [15:0] color_q;
	logic [15:0] vaddr_q;
	logic [15:0] vlatch_q;
	logic [15:0] hs_q [LAYERS];
	logic [15:0] vs_q [LAYERS];
	logic [4:0]  base_q [LAYERS];
	logic [3:0]  size_q [LAYERS];
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;
	logic [USAGE_BLOCKS-1:0]    use_vld_q;

	logic        rsp_valid_q;
	rsp_t        rsp_q;
	rsp_t        pend_q;
	logic        pal2_q;
	logic [8:0]  pal_pa_q;
	logic        rd_hi_s1;
	logic        pvld_s1;
	logic        uvld_s1;
	logic        urst_s1;
	logic [16:0] vbyte_q;
	logic [15:0] tile_q;
	logic [LAYERS-1:0] use_q;

	logic        sw_clr_q;
	logic [5:0]  sw_b_q;
	logic [2:0]  sw_cnt_q;
	logic [3:0]  sw_n_q;
	logic [5:0]  new_b_q;
	logic [3:0]  new_n_q;
	logic [LAYERS-1:0] sw_mask_q;
	logic [UAW-1:0]    sw_blk_q;

	logic accept;
	logic slot_free;
	logic rsp_load;
	logic [8:0]     pal_mod;
	logic [8:0]     blk_mod;
	logic [8:0]     sweep_mod;
	logic [PAW-1:0] pal_addr;
	logic [15:0]    pal_rdata;
	logic [15:0]    pal_wdata;
	logic           pal_we;
	logic           pal_re;
	logic [UAW-1:0] use_raddr;
	logic [UAW-1:0] vram_blk;
	logic [UAW-1:0] sweep_blk;
	logic [LAYERS-1:0] use_rdata;
	logic [LAYERS-1:0] use_word;
	logic [LAYERS-1:0] use_wdata;
	logic           use_we;
	logic           use_re;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_load  = slot_free && (state_q == S_EMIT || state_q == S_TILE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pal_mod   = mod_small({1'b0, pal_idx_q}, PAL_M);
	assign pal_addr  = pal_mod[PAW-1:0];
	assign pal_wdata = color_q | {req.write_data, 8'h00};
	assign pal_we    = accept && req.op != OP_READ && req.reg_addr == REG_PAL_DATA && pal_hi_q;
	assign pal_re    = accept && req.op == OP_READ && req.reg_addr == REG_PAL_DATA;

	assign blk_mod   = mod_small({2'b0, vaddr_q[15:9]}, USE_M);
	assign vram_blk  = blk_mod[UAW-1:0];
	assign sweep_mod = mod_small({3'b0, sw_b_q} + {6'b0, sw_cnt_q}, USE_M);
	assign sweep_blk = sweep_mod[UAW-1:0];
	assign use_re    = (accept && req.op != OP_READ && req.reg_addr == REG_VDATA_HI)
		|| state_q == S_SRD;
	assign use_raddr = (state_q == S_SRD) ? sweep_blk : vram_blk;
	assign use_word  = uvld_s1 ? use_rdata : (urst_s1 ? '1 : '0);
	assign use_wdata = sw_clr_q ? (use_word & ~sw_mask_q) : (use_word | sw_mask_q);
	assign use_we    = (state_q == S_SWR);

	vrpt_ram #(.WIDTH(16), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
		.clk     (clk),
		.wr_en   (pal_we),
		.wr_addr (pal_addr),
		.wr_data (pal_wdata),
		.rd_en   (pal_re),
		.rd_addr (pal_addr),
		.rd_data (pal_rdata)
	);

	vrpt_ram #(.WIDTH(LAYERS), .DEPTH(USAGE_BLOCKS)) u_use_ram (
		.clk     (clk),
		.wr_en   (use_we),
		.wr_addr (sw_blk_q),
		.wr_data (use_wdata),
		.rd_en   (use_re),
		.rd_addr (use_raddr),
		.rd_data (use_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			yoff_q      <= Y_OFFSET_RESET;
			pal_idx_q   <= '0;
			pal_hi_q    <= 1'b0;
			color_q     <= COLOR_RESET;
			vaddr_q     <= '0;
			vlatch_q    <= '0;
			for (int l = 0; l < LAYERS; l++) begin
				hs_q[l]   <= '0;
				vs_q[l]   <= '0;
				base_q[l] <= '0;
				size_q[l] <= '0;
			end
			pal_vld_q   <= '0;
			use_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
			pal2_q      <= 1'b0;
		end else begin
			if (cfg_we) yoff_q <= cfg_wdata;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_t nxt;
						nxt.kind           = KIND_READ;
						nxt.target_address = '0;
						nxt.data           = '0;
						nxt.last           = 1'b1;
						if (req.op == OP_READ) begin
							priority if (req.reg_addr == REG_PAL_DATA) begin
								rd_hi_s1 <= pal_hi_q;
								pvld_s1  <= pal_vld_q[pal_addr];
								if (pal_hi_q) pal_idx_q <= pal_idx_q + 8'd1;
								pal_hi_q <= !pal_hi_q;
								state_q  <= S_PRD;
							end else begin
								if (req.reg_addr == REG_PAL_INDEX) nxt.data = {8'h00, pal_idx_q};
								state_q <= S_EMIT;
							end
						end else begin
							priority if (req.reg_addr >= REG_SCREEN_FIRST
								&& req.reg_addr <= REG_SCREEN_LAST) begin
								for (int l = 0; l < LAYERS; l++) begin
									if (req.reg_addr - REG_SCREEN_FIRST == 8'(l)) begin
										base_q[l] <= req.write_data[6:2];
										new_b_q   <= {req.write_data[6:2], 1'b0};
										sw_mask_q <= LAYERS'(1) << l;
										sw_cnt_q  <= '0;
										unique case (req.write_data[1:0])
											2'd0: begin size_q[l] <= 4'd2; new_n_q <= 4'd2; end
											2'd3: begin size_q[l] <= 4'd8; new_n_q <= 4'd8; end
											default: begin size_q[l] <= 4'd4; new_n_q <= 4'd4; end
										endcase
										if (base_q[l] != req.write_data[6:2]) begin
											state_q <= S_SRD;
											// skip the clear span when nothing is held
											if (size_q[l] == 4'd0) begin
												sw_clr_q <= 1'b0;
												sw_b_q   <= {req.write_data[6:2], 1'b0};
												unique case (req.write_data[1:0])
													2'd0: sw_n_q <= 4'd2;
													2'd3: sw_n_q <= 4'd8;
													default: sw_n_q <= 4'd4;
												endcase
											end else begin
												sw_clr_q <= 1'b1;
												sw_b_q   <= {base_q[l], 1'b0};
												sw_n_q   <= size_q[l];
											end
										end
									end
								end
							end else if (req.reg_addr >= REG_SCROLL_FIRST
								&& req.reg_addr <= REG_SCROLL_LAST) begin
								for (int l = 0; l < LAYERS; l++) begin
									if ((req.reg_addr - REG_SCROLL_FIRST) >> 1 == 8'(l)) begin
										nxt.kind = KIND_SCROLL;
										if (req.reg_addr[0] == REG_SCROLL_FIRST[0]) begin
											if (!hs_q[l][15]) begin
												hs_q[l] <= {8'h80, req.write_data};
											end else begin
												hs_q[l] <= {3'b0, req.write_data[4:0], hs_q[l][7:0]};
												nxt.target_address = ADDR_HSCROLL + 32'(l * 4);
												nxt.data = {3'b0, req.write_data[4:0], hs_q[l][7:0]};
												state_q <= S_EMIT;
											end
										end else begin
											if (!vs_q[l][15]) begin
												vs_q[l] <= {8'h80, req.write_data};
											end else begin
												vs_q[l] <= {3'b0, req.write_data[4:0], vs_q[l][7:0]};
												nxt.target_address = ADDR_VSCROLL + 32'(l * 4);
												nxt.data = {3'b0, req.write_data[4:0], vs_q[l][7:0]}
													+ {8'h00, yoff_q};
												state_q <= S_EMIT;
											end
										end
									end
								end
							end else if (req.reg_addr == REG_VADDR_LO) begin
								vaddr_q[7:0] <= req.write_data;
							end else if (req.reg_addr == REG_VADDR_HI) begin
								vaddr_q[15:8] <= req.write_data;
							end else if (req.reg_addr == REG_VDATA_LO) begin
								vlatch_q[7:0] <= req.write_data;
							end else if (req.reg_addr == REG_VDATA_HI) begin
								vbyte_q  <= {vaddr_q, 1'b0};
								tile_q   <= encode_tile({req.write_data, vlatch_q[7:0]});
								uvld_s1  <= use_vld_q[vram_blk];
								urst_s1  <= (vram_blk < UAW'(2));
								vlatch_q <= '0;
								vaddr_q  <= vaddr_q + 16'd1;
								state_q  <= S_URD;
							end else if (req.reg_addr == REG_PAL_INDEX) begin
								pal_idx_q <= req.write_data;
								pal_hi_q  <= 1'b0;
							end else if (req.reg_addr == REG_PAL_DATA) begin
								if (!pal_hi_q) begin
									color_q <= {8'h00, req.write_data};
								end else begin
									color_q              <= pal_wdata;
									pal_vld_q[pal_addr]  <= 1'b1;
									pal_pa_q             <= {pal_idx_q, 1'b0};
									nxt.kind             = KIND_PALETTE;
									nxt.target_address   = ADDR_PAL_BG + {23'b0, pal_idx_q, 1'b0};
									nxt.data             = pal_wdata;
									nxt.last             = 1'b0;
									pal2_q               <= 1'b1;
									pal_idx_q            <= pal_idx_q + 8'd1;
									state_q              <= S_EMIT;
								end
								pal_hi_q <= !pal_hi_q;
							end else if (req.reg_addr == REG_LAYER_EN) begin
								nxt.kind           = KIND_ENABLE;
								nxt.target_address = ADDR_ENABLE;
								nxt.data           = {3'b0, req.write_data[4:0], 8'h00};
								state_q            <= S_EMIT;
							end else begin
							end
						end
						pend_q <= nxt;
					end
				end
				S_PRD: begin
					if (!pvld_s1) pend_q.data <= '0;
					else if (rd_hi_s1) pend_q.data <= {8'h00, pal_rdata[15:8]};
					else pend_q.data <= {8'h00, pal_rdata[7:0]};
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						rsp_q <= pend_q;
						if (pal2_q) begin
							pend_q.target_address <= ADDR_PAL_OBJ + {23'b0, pal_pa_q};
							pend_q.last           <= 1'b1;
							pal2_q                <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_URD: begin
					use_q   <= use_word;
					state_q <= (use_word == '0) ? S_IDLE : S_TILE;
				end
				S_TILE: begin
					if (slot_free) begin
						logic found;
						logic [LAYERS-1:0] rest;
						found = 1'b0;
						rest  = use_q;
						for (int l = 0; l < LAYERS; l++) begin
							if (!found && use_q[l]) begin
								found = 1'b1;
								rest[l] = 1'b0;
								rsp_q.kind <= KIND_TILEMAP;
								rsp_q.target_address <= ADDR_TILEMAP + 32'(l * 32'h2000)
									+ {15'b0, vbyte_q} - {16'b0, base_q[l], 11'b0};
								rsp_q.data <= tile_q;
							end
						end
						rsp_q.last  <= (rest == '0);
						use_q       <= rest;
						if (rest == '0) state_q <= S_IDLE;
					end
				end
				S_SRD: begin
					sw_blk_q <= sweep_blk;
					uvld_s1  <= use_vld_q[sweep_blk];
					urst_s1  <= (sweep_blk < UAW'(2));
					state_q  <= S_SWR;
				end
				S_SWR: begin
					use_vld_q[sw_blk_q] <= 1'b1;
					if ({1'b0, sw_cnt_q} + 4'd1 == sw_n_q) begin
						sw_cnt_q <= '0;
						if (sw_clr_q) begin
							// old span done, set the new one
							sw_clr_q <= 1'b0;
							sw_b_q   <= new_b_q;
							sw_n_q   <= new_n_q;
							state_q  <= S_SRD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						sw_cnt_q <= sw_cnt_q + 3'd1;
						state_q  <= S_SRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: test/video_register_port_translator_tb.sv
// Testbench for the video register port translator: directed and random accesses checked against a predictor.
`default_nettype none
module video_register_port_translator_tb;
	import vrpt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	video_register_port_translator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [15:0] pal_mem [256];
	logic [7:0]  pal_idx;
	logic        pal_hi;
	logic [15:0] color_hold;
	logic [15:0] vaddr;
	logic [15:0] vdata;
	logic [15:0] hscroll [4];
	logic [15:0] vscroll [4];
	logic [15:0] scr_base [4];
	logic [3:0]  scr_kib [4];
	logic [3:0]  blk_use [64];
	logic [7:0]  y_off;

	rsp_t expected_beats [$];
	int errors = 0;
	int accesses = 0;
	int beats_seen = 0;
	int hold_off = 0;
	bit bursty = 1'b1;

	function automatic void model_reset();
		for (int i = 0; i < 256; i++) pal_mem[i] = '0;
		for (int i = 0; i < 64; i++) blk_use[i] = (i < 2) ? 4'hF : 4'h0;
		for (int i = 0; i < 4; i++) begin
			hscroll[i] = '0; vscroll[i] = '0; scr_base[i] = '0; scr_kib[i] = '0;
		end
		pal_idx = '0; pal_hi = 1'b0; color_hold = COLOR_RESET;
		vaddr = '0; vdata = '0; y_off = Y_OFFSET_RESET;
	endfunction

	function automatic void push_beat(logic [2:0] k, logic [31:0] a, logic [15:0] d);
		rsp_t r;
		r.kind = k; r.target_address = a; r.data = d; r.last = 1'b0;
		expected_beats.push_back(r);
	endfunction

	function automatic void predict_access(req_t q);
		int prior_count;
		logic [7:0] d;
		d = q.write_data;
		prior_count = expected_beats.size();
		if (q.op == OP_READ) begin
			logic [15:0] v;
			v = '0;
			if (q.reg_addr == REG_PAL_INDEX) v = {8'h0, pal_idx};
			else if (q.reg_addr == REG_PAL_DATA) begin
				v = pal_hi ? {8'h0, pal_mem[pal_idx][15:8]} : {8'h0, pal_mem[pal_idx][7:0]};
				if (pal_hi) pal_idx++;
				pal_hi = ~pal_hi;
			end
			push_beat(KIND_READ, '0, v);
		end else if (q.reg_addr >= REG_SCREEN_FIRST && q.reg_addr <= REG_SCREEN_LAST) begin
			int n;
			logic [15:0] nb;
			logic [3:0] nk;
			n = q.reg_addr - REG_SCREEN_FIRST;
			nb = {d[6:2], 11'b0};
			nk = (d[1:0] == 2'd0) ? 4'd2 : (d[1:0] == 2'd3) ? 4'd8 : 4'd4;
			if (nb != scr_base[n]) begin
				for (int i = 0; i < scr_kib[n]; i++)
					blk_use[((scr_base[n] >> 10) + i) % 64][n] = 1'b0;
				for (int i = 0; i < nk; i++)
					blk_use[((nb >> 10) + i) % 64][n] = 1'b1;
			end
			scr_base[n] = nb; scr_kib[n] = nk;
		end else if (q.reg_addr >= REG_SCROLL_FIRST && q.reg_addr <= REG_SCROLL_LAST) begin
			int n;
			bit vert;
			logic [15:0] s;
			n = (q.reg_addr - REG_SCROLL_FIRST) >> 1;
			vert = 1'((q.reg_addr - REG_SCROLL_FIRST) & 8'd1);
			s = vert ? vscroll[n] : hscroll[n];
			if (!s[15]) s = {8'h80, d};
			else begin
				s = {3'b0, d[4:0], s[7:0]};
				if (vert) push_beat(KIND_SCROLL, ADDR_VSCROLL + 4 * n, s + y_off);
				else push_beat(KIND_SCROLL, ADDR_HSCROLL + 4 * n, s);
			end
			if (vert) vscroll[n] = s; else hscroll[n] = s;
		end else if (q.reg_addr == REG_VADDR_LO) vaddr[7:0] = d;
		else if (q.reg_addr == REG_VADDR_HI) vaddr[15:8] = d;
		else if (q.reg_addr == REG_VDATA_LO) vdata[7:0] = d;
		else if (q.reg_addr == REG_VDATA_HI) begin
			logic [31:0] a;
			logic [15:0] t, e;
			vdata[15:8] = d;
			a = {15'b0, vaddr, 1'b0};
			t = vdata;
			e = {1'b0, t[12:10], t[15], t[14], t[9:0]};
			for (int i = 0; i < 4; i++)
				if (blk_use[(a >> 10) % 64][i])
					push_beat(KIND_TILEMAP, ADDR_TILEMAP + (i << 13) + a - scr_base[i], e);
			vdata = '0; vaddr++;
		end else if (q.reg_addr == REG_PAL_INDEX) begin
			pal_idx = d; pal_hi = 1'b0;
		end else if (q.reg_addr == REG_PAL_DATA) begin
			if (!pal_hi) color_hold = {8'h0, d};
			else begin
				color_hold = color_hold | {d, 8'h0};
				pal_mem[pal_idx] = color_hold;
				push_beat(KIND_PALETTE, ADDR_PAL_BG + 2 * pal_idx, color_hold);
				push_beat(KIND_PALETTE, ADDR_PAL_OBJ + 2 * pal_idx, color_hold);
				pal_idx++;
			end
			pal_hi = ~pal_hi;
		end else if (q.reg_addr == REG_LAYER_EN)
			push_beat(KIND_ENABLE, ADDR_ENABLE, {3'b0, d[4:0], 8'h0});
		if (expected_beats.size() > prior_count) expected_beats[$].last = 1'b1;
	endfunction

	// receiver: random stall pattern, plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp_ready <= 1'b0;
		end else
			rsp_ready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			beats_seen++;
			if (expected_beats.size() == 0) begin
				$error("unexpected beat kind=%0d addr=%h data=%h", rsp.kind,
					rsp.target_address, rsp.data);
				errors++;
			end else begin
				rsp_t x;
				x = expected_beats.pop_front();
				if (rsp.kind !== x.kind) begin
					$error("kind: expected %0d got %0d", x.kind, rsp.kind); errors++;
				end
				if (rsp.target_address !== x.target_address) begin
					$error("target_address: expected %h got %h", x.target_address,
						rsp.target_address); errors++;
				end
				if (rsp.data !== x.data) begin
					$error("data: expected %h got %h", x.data, rsp.data); errors++;
				end
				if (rsp.last !== x.last) begin
					$error("last: expected %0d got %0d", x.last, rsp.last); errors++;
				end
			end
		end
	end

	task automatic send_access(logic o, logic [7:0] ra, logic [7:0] d);
		req_t q;
		q.op = o; q.reg_addr = ra; q.write_data = d;
		req_valid <= 1'b1;
		req <= q;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_access(q);
		accesses++;
		// random gap between bursts
		if (bursty && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		// screen base walks emit nothing; let them finish
		repeat (40) @(posedge clk);
	endtask

	task automatic write_y_offset(logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		y_off = v;
	endtask

	task automatic set_scroll(int n, bit vert, logic [7:0] lo, logic [7:0] hi);
		send_access(1'b1, 8'(REG_SCROLL_FIRST + 2 * n + vert), lo);
		send_access(1'b1, 8'(REG_SCROLL_FIRST + 2 * n + vert), hi);
	endtask

	task automatic vram_word(logic [15:0] wa, logic [15:0] t);
		send_access(1'b1, REG_VADDR_LO, wa[7:0]);
		send_access(1'b1, REG_VADDR_HI, wa[15:8]);
		send_access(1'b1, REG_VDATA_LO, t[7:0]);
		send_access(1'b1, REG_VDATA_HI, t[15:8]);
	endtask

	task automatic test_directed();
		send_access(1'b0, REG_PAL_DATA, 8'h00);
		send_access(1'b0, REG_PAL_DATA, 8'hFF);
		send_access(1'b1, REG_PAL_INDEX, 8'hFF);
		send_access(1'b1, REG_PAL_DATA, 8'hFF);
		send_access(1'b1, REG_PAL_DATA, 8'hFF);
		send_access(1'b0, REG_PAL_INDEX, 8'h00);
		set_scroll(0, 1'b0, 8'hFF, 8'hFF);
		set_scroll(3, 1'b1, 8'hF5, 8'h1F);
		send_access(1'b1, REG_LAYER_EN, 8'hFF);
		vram_word(16'hFFFF, 16'hFFFF);
		vram_word(16'h0000, 16'h5A5A);
		send_access(1'b1, REG_SCREEN_LAST, 8'hFF);
		send_access(1'b1, REG_SCREEN_FIRST, 8'hFC);
		send_access(1'b1, 8'h05, 8'h00);
		send_access(1'b0, 8'hFF, 8'hAA);
	endtask

	// mostly well-formed register sequences with random content
	task automatic random_access();
		logic [7:0] d;
		d = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: send_access(1'b1, 8'(REG_SCREEN_FIRST + $urandom_range(0, 3)), d);
			1, 2: set_scroll($urandom_range(0, 3), 1'($urandom_range(0, 1)), d,
				8'($urandom_range(0, 255)));
			3, 4: vram_word(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			5: begin
				send_access(1'b1, REG_PAL_DATA, d);
				send_access(1'b1, REG_PAL_DATA, 8'($urandom_range(0, 255)));
			end
			6: send_access(1'b0, $urandom_range(0, 1) ? REG_PAL_DATA : REG_PAL_INDEX, d);
			7: send_access(1'b1, $urandom_range(0, 1) ? REG_PAL_INDEX : REG_LAYER_EN, d);
			default: send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), d);
		endcase
	endtask

	task automatic test_random(int count);
		int start;
		start = accesses;
		while (accesses - start < count) random_access();
	endtask

	task automatic test_backpressure();
		drain();
		hold_off = 300;
		bursty = 1'b0;
		repeat (12) send_access(1'b1, REG_LAYER_EN, 8'($urandom_range(0, 255)));
		bursty = 1'b1;
		drain();
	endtask

	initial begin
		model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_y_offset(8'h00);
		set_scroll(1, 1'b1, 8'h00, 8'h00);
		test_random(100);
		write_y_offset(8'hFF);
		set_scroll(2, 1'b1, 8'hFF, 8'h1F);
		test_random(100);
		test_backpressure();
		write_y_offset(8'($urandom_range(1, 254)));
		bursty = 1'b0;
		test_random(60);
		bursty = 1'b1;
		test_random(80);
		drain();
		if (expected_beats.size() != 0) begin
			$error("beats: expected %0d more got 0", expected_beats.size());
			errors++;
		end
		$display("Covered %0d accesses, %0d result beats, under stalls and y offsets.",
			accesses, beats_seen);
		if (errors == 0)
			$display("PASS video_register_port_translator");
		else
			$display("FAIL video_register_port_translator");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL video_register_port_translator");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
rtl/vrpt_pkg.sv
rtl/vrpt_ram.sv
rtl/video_register_port_translator.sv
test/video_register_port_translator_tb.sv
